@@ rtl/b2da_pkg.sv @@
// shared types and constants for the binary to decimal ascii converter
// no dependencies
package b2da_pkg;

  localparam int unsigned ValueW     = 16;
  localparam int unsigned CharW      = 6;
  localparam int unsigned NumDigits  = 5;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned IdxW       = 3;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam int unsigned RecipW     = 17;
  localparam logic [RecipW-1:0] RecipMul = 17'd52429;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = ValueW + RecipW;

  localparam logic [CharW-1:0] AsciiZero = 6'd48;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = 1;
  localparam int unsigned CountW     = 2;

  typedef logic [DigitW-1:0] digit_t;

  typedef struct packed {
    logic [NumDigits-1:0][DigitW-1:0] digits; // digits[0] is least significant
    logic [IdxW-1:0]                  ndig;   // number of digits, 1 to 5
  } entry_t;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_CONV
  } front_state_e;

endpackage

@@ rtl/binary_to_decimal_ascii_digits.sv @@
// binary to decimal ascii converter, top level; uses b2da_pkg, b2da_front,
// b2da_queue and b2da_back
// a value with n decimal digits (1 to 5) is taken while the front end is idle, goes
// through n divide-by-ten steps and is pushed once the queue is not full; no new value
// is accepted before then; the characters pass through the queue and the output
// register, one per cycle while pop is high; reset empties queue and output register
module binary_to_decimal_ascii_digits (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [b2da_pkg::ValueW-1:0] value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [b2da_pkg::CharW-1:0]  digit_char_o,
  output logic                        last_o
);
  import b2da_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_wr_entry;
  entry_t q_rd_entry;

  b2da_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .value_i   (value_i),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry),
    .q_full_i  (q_full)
  );

  b2da_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  b2da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_entry_i    (q_rd_entry),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

@@ rtl/b2da_front.sv @@
// front end: takes a binary value and splits it into decimal digits,
// one divide by ten per cycle, stalls on a full queue; uses b2da_pkg
module b2da_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [b2da_pkg::ValueW-1:0]   value_i,
  output logic                          q_push_o,
  output b2da_pkg::entry_t              q_entry_o,
  input  logic                          q_full_i
);
  import b2da_pkg::*;

  front_state_e                     state_q, state_d;
  logic [ValueW-1:0]                rem_q, rem_d;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic [NumDigits-1:0][DigitW-1:0] digits_q, digits_d;

  logic [ProdW-1:0]  prod;
  logic [ValueW-1:0] quo;
  logic [ValueW-1:0] ten_quo;
  logic [ValueW-1:0] diff;
  digit_t            dig;
  logic              final_step;
  logic              accept;
  logic              step_en;
  logic [NumDigits-1:0][DigitW-1:0] digits_w;

  assign prod    = ProdW'(rem_q) * ProdW'(RecipMul);
  assign quo     = ValueW'(prod >> RecipShift);
  assign ten_quo = (quo << 3) + (quo << 1);
  assign diff    = rem_q - ten_quo;
  assign dig     = diff[DigitW-1:0];
  assign final_step = (quo == '0);

  always_comb begin
    digits_w = digits_q;
    digits_w[idx_q] = dig;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FRONT_IDLE: begin
        if (push) state_d = FRONT_CONV;
      end
      FRONT_CONV: begin
        if (final_step && !q_full_i) state_d = FRONT_IDLE;
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    full     = 1'b1;
    accept   = 1'b0;
    step_en  = 1'b0;
    q_push_o = 1'b0;
    unique case (state_q)
      FRONT_IDLE: begin
        full   = 1'b0;
        accept = push;
      end
      FRONT_CONV: begin
        step_en  = !final_step;
        q_push_o = final_step && !q_full_i;
      end
      default: full = 1'b1;
    endcase
  end

  assign q_entry_o.digits = digits_w;
  assign q_entry_o.ndig   = idx_q + IdxW'(1);

  always_comb begin
    rem_d    = rem_q;
    idx_d    = idx_q;
    digits_d = digits_q;
    if (accept) begin
      rem_d = value_i;
      idx_d = '0;
    end else if (step_en) begin
      rem_d    = quo;
      idx_d    = idx_q + IdxW'(1);
      digits_d = digits_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    digits_q <= digits_d;
  end

endmodule

@@ rtl/b2da_queue.sv @@
// two-entry queue of converted digit groups between front and back end
// uses b2da_pkg
module b2da_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b2da_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output b2da_pkg::entry_t entry_o,
  output logic             empty_o
);
  import b2da_pkg::*;

  entry_t              mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CountW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop)      count_d = count_q + CountW'(1);
    else if (do_pop && !do_push) count_d = count_q - CountW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

@@ rtl/b2da_back.sv @@
// back end: walks a digit group most significant first and hands out
// one ascii character per cycle through an output register; uses b2da_pkg
module b2da_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  b2da_pkg::entry_t            q_entry_i,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [b2da_pkg::CharW-1:0]  digit_char_o,
  output logic                        last_o
);
  import b2da_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic              started_q, started_d;
  logic [IdxW-1:0]   pos_q, pos_d;
  logic [IdxW-1:0]   pos_sel;
  logic              load_en;
  logic              emit;
  logic              is_last;

  assign load_en = !out_valid_q || pop;
  assign emit    = load_en && !q_empty_i;
  // first digit of a group sits at the top of its run
  assign pos_sel = started_q ? pos_q : q_entry_i.ndig - IdxW'(1);
  assign is_last = (pos_sel == '0);
  assign q_pop_o = emit && is_last;

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    started_d   = started_q;
    pos_d       = pos_q;
    if (load_en) begin
      out_valid_d = emit;
      if (emit) begin
        char_d    = CharW'(q_entry_i.digits[pos_sel]) + AsciiZero;
        last_d    = is_last;
        started_d = !is_last;
        pos_d     = pos_sel - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign empty        = !out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule
